[sv/tfc_pkg.sv]
`default_nettype none

package tfc_pkg;

  // Storage shape
  localparam int SENSOR_SLOTS = 3;
  localparam int ROWS         = 3;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int SENS_W   = 2;
  localparam int RAW_W    = 16;
  localparam int GAIN_W   = 7;
  localparam int STAT_W   = 3;
  localparam int FORCE_W  = 33;
  localparam int TDELTA_W = 25;
  localparam int CFG_IDX_W = 2;

  // State widths
  localparam int SUM_W  = 48;
  localparam int TSUM_W = 24;
  localparam int CNT_W  = 8;
  localparam int OFS_W  = 40;
  localparam int TOFS_W = 33;

  // Datapath widths
  localparam int COEF_W  = 24;
  localparam int ACC_W   = 50;
  localparam int DT_W    = 34;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DVD_W   = 52;
  localparam int DVS_W   = 9;
  localparam int REM_W   = DVS_W + 1;

  // Divider: radix-2 steps folded per cycle
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = DVD_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  // Output scale divisor
  localparam int OUT_DIV = 310;

  // Force saturation limits on the quotient magnitude
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(64'h0_FFFF_FFFF);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'h1_0000_0000);
  localparam logic [FORCE_W-1:0] FORCE_MAX = 33'h0_FFFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_MIN = 33'h1_0000_0000;

  // Gain register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_RESET [SENSOR_SLOTS] = '{
    -7'sd12, -7'sd5, -7'sd9
  };

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MEASURE = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_ACCUM   = 2'd2,
    FUNC_FINISH  = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_MEASURED    = 3'd0,
    STAT_CLEARED     = 3'd1,
    STAT_ACCUMULATED = 3'd2,
    STAT_DONE        = 3'd3,
    STAT_FAILED      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_WRITE,
    ST_RESULT
  } state_e;

  // Q8.16 calibration matrices, row-major (x, y, z rows)
  function automatic logic signed [COEF_W-1:0] cal_coef(input logic [SENS_W-1:0] sensor,
                                                      input logic [3:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (sensor)
      2'd0: begin
        case (idx)
          4'd0: c = 24'sd649522;
          4'd1: c = 24'sd80687;
          4'd2: c = 24'sd63626;
          4'd3: c = -24'sd129332;
          4'd4: c = 24'sd961410;
          4'd5: c = -24'sd60406;
          4'd6: c = 24'sd41353;
          4'd7: c = -24'sd50542;
          4'd8: c = 24'sd3644674;
          default: c = '0;
        endcase
      end
      2'd1: begin
        case (idx)
          4'd0: c = 24'sd731216;
          4'd1: c = 24'sd79695;
          4'd2: c = 24'sd151966;
          4'd3: c = -24'sd113275;
          4'd4: c = 24'sd793438;
          4'd5: c = 24'sd6237;
          4'd6: c = 24'sd12365;
          4'd7: c = -24'sd105584;
          4'd8: c = 24'sd3360834;
          default: c = '0;
        endcase
      end
      2'd2: begin
        case (idx)
          4'd0: c = 24'sd746164;
          4'd1: c = 24'sd70505;
          4'd2: c = 24'sd22388;
          4'd3: c = -24'sd87466;
          4'd4: c = 24'sd852433;
          4'd5: c = -24'sd133495;
          4'd6: c = 24'sd59602;
          4'd7: c = -24'sd167421;
          4'd8: c = 24'sd3389857;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/tfc_if.sv]
`default_nettype none

// Input sample channel
interface tfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  sensor;
  logic [15:0] raw_a;
  logic [15:0] raw_b;
  logic [15:0] raw_c;
  logic [15:0] raw_temp;

  modport source (output valid, func, sensor, raw_a, raw_b, raw_c, raw_temp, input ready);
  modport sink   (input valid, func, sensor, raw_a, raw_b, raw_c, raw_temp, output ready);
endinterface

// Result channel
interface tfc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [1:0]         sensor_out;
  logic signed [32:0] force_x;
  logic signed [32:0] force_y;
  logic signed [32:0] force_z;
  logic signed [24:0] temp_delta;

  modport source (output valid, status, sensor_out, force_x, force_y, force_z, temp_delta,
                  input ready);
  modport sink   (input valid, status, sensor_out, force_x, force_y, force_z, temp_delta,
                  output ready);
endinterface

`default_nettype wire

[sv/tfc_divider.sv]
`default_nettype none

// Unsigned restoring divider, DIV_STEP_BITS quotient bits per cycle.
module tfc_divider import tfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  // Folded shift/compare/subtract steps
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] t;
    logic [DVD_W-1:0] d;
    r = rem_q;
    d = dvd_q;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t = {r[REM_W-2:0], d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        r    = t - {1'b0, dvs_q};
        d[0] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_d = r;
    dvd_d = d;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_CYCLES - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

[sv/tactile_force_calibrator_top.sv]
// Throughput: one sample at a time; each division runs in the shared divider and
//   each matrix product goes through the single 34x17 multiplier.
// Reset: asynchronous, active low; clears sums, counts, offsets and restores gains.
`default_nettype none

module tactile_force_calibrator_top import tfc_pkg::*; #(
  parameter int NUM_SENSORS = 3,
  parameter int MAX_SAMPLES = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  tfc_in_if.sink               in_i,
  tfc_out_if.source            out_o
);

  state_e state_q, state_d;

  // Captured transaction
  func_e                    func_q;
  logic [SENS_W-1:0]        sensor_q;
  logic [RAW_W-1:0]         raw_q [ROWS];
  logic [RAW_W-1:0]         temp_q;

  // Sequencer indexes: k is the row (3 means temperature), j the product step
  logic [1:0]               k_q;
  logic [2:0]               j_q;

  // Datapath registers
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DT_W-1:0]   dt_q;
  logic                     neg_q;
  logic [DVS_W-1:0]         divisor_q;

  // Result registers
  status_e                  status_q;
  logic signed [FORCE_W-1:0]  force_x_q, force_y_q, force_z_q;
  logic signed [TDELTA_W-1:0] temp_delta_q;

  // Calibration state
  logic signed [GAIN_W-1:0] gain_q       [SENSOR_SLOTS];
  logic signed [SUM_W-1:0]  force_sum_q  [SENSOR_SLOTS][ROWS];
  logic [TSUM_W-1:0]        temp_sum_q   [SENSOR_SLOTS];
  logic [CNT_W-1:0]         count_q      [SENSOR_SLOTS];
  logic signed [OFS_W-1:0]  force_ofs_q  [SENSOR_SLOTS][ROWS];
  logic [TOFS_W-1:0]        temp_ofs_q   [SENSOR_SLOTS];

  // FSM outputs
  logic in_ready;
  logic out_valid;
  logic div_start;

  logic                     in_accept;
  logic                     sensor_ok;
  logic [CNT_W-1:0]         count_cur;
  logic                     count_full;
  logic                     count_zero;
  logic [2:0]               nprod;
  logic                     write_last;
  logic [3:0]               coef_idx;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [GAIN_W:0]   gain_neg;
  logic [DVD_W-1:0]         acc_ext;
  logic [DVD_W-1:0]         half_ext;
  logic [DVD_W-1:0]         dividend;
  logic                     div_done;
  logic [DVD_W-1:0]         quot;
  logic [DVD_W-1:0]         q_signed;
  logic [FORCE_W-1:0]       force_val;

  // Decode of the current transaction
  assign in_accept  = in_i.valid && in_ready;
  assign sensor_ok  = (int'(in_i.sensor) < NUM_SENSORS) && (int'(in_i.sensor) < SENSOR_SLOTS);
  assign count_cur  = count_q[sensor_q];
  assign count_full = count_cur >= CNT_W'(MAX_SAMPLES);
  assign count_zero = count_cur == '0;
  assign nprod      = (func_q == FUNC_MEASURE && k_q == 2'd2) ? 3'd4 : 3'd3;
  assign write_last = (func_q == FUNC_ACCUM) ? (k_q == 2'd2) : (k_q == 2'd3);

  // Shared multiplier operands: matrix coefficient times raw channel,
  // or drift times negated gain on the last step of the z row
  assign coef_idx = 4'({2'b00, k_q} * 4'd3) + {2'b00, j_q[1:0]};
  assign gain_neg = -{gain_q[sensor_q][GAIN_W-1], gain_q[sensor_q]};

  always_comb begin
    if (j_q < 3'd3) begin
      mul_a = MUL_A_W'(cal_coef(sensor_q, coef_idx));
      mul_b = $signed({1'b0, raw_q[j_q[1:0]]});
    end else begin
      mul_a = dt_q;
      mul_b = MUL_B_W'(gain_neg);
    end
  end

  // Rounding: magnitude plus half divisor, sign kept aside
  assign acc_ext  = {{(DVD_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
  assign half_ext = {{(DVD_W-DVS_W+1){1'b0}}, divisor_q[DVS_W-1:1]};
  assign dividend = acc_q[ACC_W-1] ? (half_ext - acc_ext) : (acc_ext + half_ext);

  tfc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Signed quotient and force saturation
  assign q_signed = neg_q ? ('0 - quot) : quot;

  always_comb begin
    if (!neg_q && quot > POS_LIM) begin
      force_val = FORCE_MAX;
    end else if (neg_q && quot > NEG_LIM) begin
      force_val = FORCE_MIN;
    end else begin
      force_val = q_signed[FORCE_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && sensor_ok) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        unique case (func_q)
          FUNC_CLEAR:   state_d = ST_RESULT;
          FUNC_ACCUM:   state_d = count_full ? ST_RESULT : ST_MUL;
          FUNC_FINISH:  state_d = count_zero ? ST_RESULT : ST_PREP;
          FUNC_MEASURE: state_d = (k_q == 2'd3) ? ST_PREP : ST_MUL;
          default:      state_d = ST_RESULT;
        endcase
      end
      ST_MUL: begin
        if (j_q == nprod) state_d = (func_q == FUNC_ACCUM) ? ST_WRITE : ST_PREP;
      end
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = write_last ? ST_RESULT : ST_LOAD;
      ST_RESULT: begin
        if (out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready  = 1'b1;
      ST_PREP:   div_start = 1'b1;
      ST_RESULT: out_valid = 1'b1;
      default:   ;
    endcase
  end

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSOR_SLOTS; s++) gain_q[s] <= GAIN_RESET[s];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        2'd0:    gain_q[0] <= cfg_data_i;
        2'd1:    gain_q[1] <= cfg_data_i;
        2'd2:    gain_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      for (int s = 0; s < SENSOR_SLOTS; s++) begin
        for (int r = 0; r < ROWS; r++) begin
          force_sum_q[s][r] <= '0;
          force_ofs_q[s][r] <= '0;
        end
        temp_sum_q[s] <= '0;
        count_q[s]    <= '0;
        temp_ofs_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: k_q <= '0;
        ST_LOAD: begin
          j_q <= '0;
          if (func_q == FUNC_CLEAR) begin
            for (int r = 0; r < ROWS; r++) force_sum_q[sensor_q][r] <= '0;
            temp_sum_q[sensor_q] <= '0;
            count_q[sensor_q]    <= '0;
          end
        end
        ST_MUL: j_q <= j_q + 3'd1;
        ST_WRITE: begin
          k_q <= k_q + 2'd1;
          if (func_q == FUNC_ACCUM) begin
            force_sum_q[sensor_q][k_q] <= acc_q[SUM_W-1:0];
            if (k_q == 2'd2) begin
              temp_sum_q[sensor_q] <= temp_sum_q[sensor_q] + TSUM_W'(temp_q);
              count_q[sensor_q]    <= count_q[sensor_q] + 1'b1;
            end
          end else if (func_q == FUNC_FINISH) begin
            if (k_q == 2'd3) begin
              temp_ofs_q[sensor_q] <= quot[TOFS_W-1:0];
            end else begin
              force_ofs_q[sensor_q][k_q] <= q_signed[OFS_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          func_q       <= func_e'(in_i.func);
          sensor_q     <= in_i.sensor;
          raw_q[0]     <= in_i.raw_a;
          raw_q[1]     <= in_i.raw_b;
          raw_q[2]     <= in_i.raw_c;
          temp_q       <= in_i.raw_temp;
          force_x_q    <= '0;
          force_y_q    <= '0;
          force_z_q    <= '0;
          temp_delta_q <= '0;
          case (func_e'(in_i.func))
            FUNC_MEASURE: status_q <= STAT_MEASURED;
            FUNC_CLEAR:   status_q <= STAT_CLEARED;
            FUNC_ACCUM:   status_q <= STAT_ACCUMULATED;
            default:      status_q <= STAT_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        case (func_q)
          FUNC_MEASURE: begin
            divisor_q <= DVS_W'(OUT_DIV);
            if (k_q == 2'd0) begin
              dt_q <= $signed({2'b00, temp_q, 16'h0000}) - $signed({1'b0, temp_ofs_q[sensor_q]});
            end
            if (k_q == 2'd3) begin
              acc_q <= ACC_W'(dt_q);
            end else begin
              acc_q <= '0 - ACC_W'(force_ofs_q[sensor_q][k_q]);
            end
          end
          FUNC_ACCUM: acc_q <= ACC_W'(force_sum_q[sensor_q][k_q]);
          FUNC_FINISH: begin
            divisor_q <= {1'b0, count_cur};
            if (count_zero) status_q <= STAT_FAILED;
            if (k_q == 2'd3) begin
              acc_q <= $signed({{(ACC_W-TSUM_W-16){1'b0}}, temp_sum_q[sensor_q], 16'h0000});
            end else begin
              acc_q <= ACC_W'(force_sum_q[sensor_q][k_q]);
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        if (j_q < nprod) prod_q <= mul_a * mul_b;
        if (j_q != 3'd0) acc_q <= acc_q + $signed(prod_q[ACC_W-1:0]);
      end
      ST_PREP: neg_q <= acc_q[ACC_W-1];
      ST_WRITE: begin
        if (func_q == FUNC_MEASURE) begin
          case (k_q)
            2'd0:    force_x_q    <= force_val;
            2'd1:    force_y_q    <= force_val;
            2'd2:    force_z_q    <= force_val;
            default: temp_delta_q <= q_signed[TDELTA_W-1:0];
          endcase
        end
      end
      default: ;
    endcase
  end

  // Port drive
  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.status     = status_q;
  assign out_o.sensor_out = sensor_q;
  assign out_o.force_x    = force_x_q;
  assign out_o.force_y    = force_y_q;
  assign out_o.force_z    = force_z_q;
  assign out_o.temp_delta = temp_delta_q;

endmodule

`default_nettype wire

[sv/tfc_checker.sv]
`default_nettype none

module tfc_checker import tfc_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [STAT_W-1:0]          status,
  input logic [SENS_W-1:0]          sensor_out,
  input logic signed [FORCE_W-1:0]  force_x,
  input logic signed [FORCE_W-1:0]  force_y,
  input logic signed [FORCE_W-1:0]  force_z,
  input logic signed [TDELTA_W-1:0] temp_delta
);

  // A pending result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(status) && $stable(sensor_out) &&
                                $stable(force_x) && $stable(force_y) &&
                                $stable(force_z) && $stable(temp_delta))
    else $error("result payload changed while stalled");

  // One sample in flight: no new input while a result waits
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // Calibration results carry zero forces and temperature delta
  a_zero_unless_measured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != STAT_MEASURED) |->
      force_x == '0 && force_y == '0 && force_z == '0 && temp_delta == '0)
    else $error("nonzero force on calibration result");

endmodule

bind tactile_force_calibrator_top tfc_checker u_tfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .status     (out_o.status),
  .sensor_out (out_o.sensor_out),
  .force_x    (out_o.force_x),
  .force_y    (out_o.force_y),
  .force_z    (out_o.force_z),
  .temp_delta (out_o.temp_delta)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tfc_pkg::*;

  // Register indexes of the gain port; the last one is not mapped
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED    = 2'd3;

  localparam int          SENSORS      = 3;
  localparam int          SAMPLE_CAP   = 255;
  localparam int          SCALE_DIV    = 310;
  localparam int          SETTLE_CYC   = 120;
  localparam int          HOLD_CYC     = 400;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          PRINT_CAP    = 40;
  localparam logic [1:0]  SENSOR_BAD   = 2'd3;

  typedef struct packed {
    func_e       func;
    logic [1:0]  sensor;
    logic [15:0] raw_a;
    logic [15:0] raw_b;
    logic [15:0] raw_c;
    logic [15:0] raw_temp;
  } sample_t;

  typedef struct packed {
    status_e            status;
    logic [1:0]         sensor;
    logic signed [32:0] fx;
    logic signed [32:0] fy;
    logic signed [32:0] fz;
    logic signed [24:0] tdelta;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [GAIN_W-1:0]    cfg_data_i = '0;

  tfc_in_if  in_if();
  tfc_out_if out_if();

  tactile_force_calibrator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Q8.16 calibration matrices, rows x, y, z
  int cal_q16 [3][9] = '{
    '{649522, 80687, 63626, -129332, 961410, -60406, 41353, -50542, 3644674},
    '{731216, 79695, 151966, -113275, 793438, 6237, 12365, -105584, 3360834},
    '{746164, 70505, 22388, -87466, 852433, -133495, 59602, -167421, 3389857}
  };

  // Mirror of the calibration state
  logic signed [GAIN_W-1:0] drift_gain [SENSORS];
  longint      force_acc   [SENSORS][3];
  int unsigned temp_acc    [SENSORS];
  int unsigned acc_count   [SENSORS];
  longint      force_zero  [SENSORS][3];
  longint      temp_zero   [SENSORS];

  reading_t pending_readings [$];
  reading_t want_r;

  int errors     = 0;
  int n_items    = 0;
  int n_ignored  = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int stall_cycles = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  // One line per mismatch, output capped
  task automatic report_mismatch(input string what);
    if (errors < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [32:0] clamp33(input longint v);
    if (v > 64'sd4294967295) return FORCE_MAX;
    if (v < -64'sd4294967296) return FORCE_MIN;
    return v[32:0];
  endfunction

  // Work out the reading for one accepted sample and update the state
  task automatic predict_calibration(input sample_t smp);
    longint   row [3];
    longint   raw [3];
    longint   dt;
    longint   vz;
    longint   cnt;
    reading_t r;
    int       s;
    if (smp.sensor >= SENSORS) return;
    s = smp.sensor;
    raw[0] = longint'(smp.raw_a);
    raw[1] = longint'(smp.raw_b);
    raw[2] = longint'(smp.raw_c);
    for (int k = 0; k < 3; k++) begin
      row[k] = 0;
      for (int j = 0; j < 3; j++) row[k] += longint'(cal_q16[s][k*3+j]) * raw[j];
    end
    r = '0;
    r.sensor = smp.sensor;
    case (smp.func)
      FUNC_MEASURE: begin
        dt = longint'(smp.raw_temp) * 65536 - temp_zero[s];
        vz = row[2] - force_zero[s][2] - dt * longint'(drift_gain[s]);
        r.status = STAT_MEASURED;
        r.fx = clamp33(round_div(row[0] - force_zero[s][0], SCALE_DIV));
        r.fy = clamp33(round_div(row[1] - force_zero[s][1], SCALE_DIV));
        r.fz = clamp33(round_div(vz, SCALE_DIV));
        r.tdelta = 25'(round_div(dt, SCALE_DIV));
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < 3; k++) force_acc[s][k] = 0;
        temp_acc[s] = 0;
        acc_count[s] = 0;
        r.status = STAT_CLEARED;
      end
      FUNC_ACCUM: begin
        // saturated count leaves the sums alone
        if (acc_count[s] < SAMPLE_CAP) begin
          for (int k = 0; k < 3; k++) force_acc[s][k] += row[k];
          temp_acc[s] += smp.raw_temp;
          acc_count[s]++;
        end
        r.status = STAT_ACCUMULATED;
      end
      default: begin
        cnt = acc_count[s];
        if (cnt == 0) begin
          r.status = STAT_FAILED;
        end else begin
          for (int k = 0; k < 3; k++) force_zero[s][k] = round_div(force_acc[s][k], cnt);
          temp_zero[s] = round_div(longint'(temp_acc[s]) * 65536, cnt);
          r.status = STAT_DONE;
        end
      end
    endcase
    pending_readings.push_back(r);
  endtask

  // Offer one sample, with an optional random gap, until the block takes it
  task automatic send_sample(input sample_t smp);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= smp.func;
    in_if.sensor   <= smp.sensor;
    in_if.raw_a    <= smp.raw_a;
    in_if.raw_b    <= smp.raw_b;
    in_if.raw_c    <= smp.raw_c;
    in_if.raw_temp <= smp.raw_temp;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_calibration(smp);
    if (smp.sensor < SENSORS) n_items++;
    else n_ignored++;
  endtask

  function automatic sample_t pack_sample(input func_e f, input logic [1:0] sid,
                                          input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c, input logic [15:0] t);
    sample_t smp;
    smp.func = f;
    smp.sensor = sid;
    smp.raw_a = a;
    smp.raw_b = b;
    smp.raw_c = c;
    smp.raw_temp = t;
    return smp;
  endfunction

  // Raw reading near a base value, with some extremes and wild values mixed in
  function automatic logic [15:0] jitter(input logic [15:0] base);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return 16'h0000;
    if (mode == 1) return 16'hFFFF;
    if (mode <= 3) return 16'($urandom_range(0, 65535));
    return base + 16'($urandom_range(0, 255)) - 16'd128;
  endfunction

  function automatic sample_t near_sample(input func_e f, input logic [1:0] sid,
                                          input logic [3:0][15:0] base);
    return pack_sample(f, sid, jitter(base[0]), jitter(base[1]), jitter(base[2]),
                       jitter(base[3]));
  endfunction

  function automatic sample_t noise_sample();
    return pack_sample(func_e'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endfunction

  // An optional clear, a few samples, finish, then measurements on one sensor
  task automatic run_calibration(input logic [1:0] sid);
    logic [3:0][15:0] base;
    int n_acc;
    int n_meas;
    for (int i = 0; i < 4; i++) base[i] = 16'($urandom_range(0, 65535));
    n_acc = $urandom_range(0, 6);
    n_meas = $urandom_range(1, 4);
    if ($urandom_range(0, 5) != 0) send_sample(near_sample(FUNC_CLEAR, sid, base));
    for (int i = 0; i < n_acc; i++) send_sample(near_sample(FUNC_ACCUM, sid, base));
    send_sample(near_sample(FUNC_FINISH, sid, base));
    for (int i = 0; i < n_meas; i++) send_sample(near_sample(FUNC_MEASURE, sid, base));
  endtask

  // Drop valid, wait for every reading, then let a dropped sample finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx != REG_UNMAPPED) drift_gain[idx] = data;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                           input logic [GAIN_W-1:0] g2);
    write_reg(REG_GAIN_FIRST, g0);
    write_reg(REG_GAIN_SECOND, g1);
    write_reg(REG_GAIN_THIRD, g2);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYC;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each reading against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with nothing pending");
      end else begin
        want_r = pending_readings.pop_front();
        n_checked++;
        if (out_if.status !== want_r.status)
          report_mismatch($sformatf("status got %0d want %0d", out_if.status,
                                    want_r.status));
        if (out_if.sensor_out !== want_r.sensor)
          report_mismatch($sformatf("sensor got %0d want %0d", out_if.sensor_out,
                                    want_r.sensor));
        if (out_if.force_x !== want_r.fx)
          report_mismatch($sformatf("force_x got %0d want %0d", out_if.force_x, want_r.fx));
        if (out_if.force_y !== want_r.fy)
          report_mismatch($sformatf("force_y got %0d want %0d", out_if.force_y, want_r.fy));
        if (out_if.force_z !== want_r.fz)
          report_mismatch($sformatf("force_z got %0d want %0d", out_if.force_z, want_r.fz));
        if (out_if.temp_delta !== want_r.tdelta)
          report_mismatch($sformatf("temp_delta got %0d want %0d", out_if.temp_delta,
                                    want_r.tdelta));
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d readings pending",
               stall_cycles, pending_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset values, extremes of the raw fields, ignored sensor code, empty finish
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    send_sample(pack_sample(FUNC_FINISH, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pack_sample(FUNC_MEASURE, 2'd2, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, SENSOR_BAD, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF));
    send_sample(pack_sample(FUNC_CLEAR, SENSOR_BAD, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
    send_sample(pack_sample(FUNC_CLEAR, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_FINISH, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pack_sample(FUNC_ACCUM, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pack_sample(FUNC_ACCUM, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pack_sample(FUNC_ACCUM, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_FINISH, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, 2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(pack_sample(FUNC_CLEAR, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_ACCUM, 2'd0, 16'h8000, 16'h4000, 16'h2000, 16'h7FFF));
    send_sample(pack_sample(FUNC_FINISH, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, 2'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_sample(pack_sample(FUNC_ACCUM, 2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_FINISH, 2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(FUNC_MEASURE, 2'd2, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    wait_idle();
  endtask

  // Gain extremes, and a write to the unmapped index that must change nothing
  task automatic test_gain_extremes();
    set_gains(7'h40, 7'h3F, 7'h00);
    for (int s = 0; s < SENSORS; s++)
      send_sample(pack_sample(FUNC_MEASURE, 2'(s), 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    wait_idle();
    write_reg(REG_GAIN_FIRST, 7'h3F);
    write_reg(REG_GAIN_SECOND, 7'h40);
    write_reg(REG_GAIN_THIRD, 7'h7F);
    write_reg(REG_UNMAPPED, 7'h55);
    cfg_we_i <= 1'b0;
    n_settings++;
    for (int s = 0; s < SENSORS; s++)
      send_sample(pack_sample(FUNC_MEASURE, 2'(s), 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    wait_idle();
  endtask

  // Run past the sample cap on one sensor, then finish and measure
  task automatic test_count_saturation();
    logic [3:0][15:0] base;
    for (int i = 0; i < 4; i++) base[i] = 16'($urandom_range(0, 65535));
    send_sample(near_sample(FUNC_CLEAR, 2'd2, base));
    for (int i = 0; i < SAMPLE_CAP + 4; i++) send_sample(near_sample(FUNC_ACCUM, 2'd2, base));
    send_sample(near_sample(FUNC_FINISH, 2'd2, base));
    for (int i = 0; i < 3; i++) send_sample(near_sample(FUNC_MEASURE, 2'd2, base));
    wait_idle();
  endtask

  // Long receiver hold-off while samples keep coming, so the input backs up
  task automatic test_output_backpressure();
    int stop_at;
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    stop_at = n_items + 30;
    while (n_items < stop_at) run_calibration(2'($urandom_range(0, 2)));
    wait_idle();
  endtask

  // Mostly calibration sequences with random content, some noise
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    int stop_at;
    set_gains(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
    send_idle_pct = s_pct;
    recv_stall_pct <= r_pct;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 9) < 8) run_calibration(2'($urandom_range(0, 2)));
      else send_sample(noise_sample());
    end
    wait_idle();
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_MEASURE;
    in_if.sensor   = '0;
    in_if.raw_a    = '0;
    in_if.raw_b    = '0;
    in_if.raw_c    = '0;
    in_if.raw_temp = '0;
    out_if.ready   = 1'b0;
    for (int s = 0; s < SENSORS; s++) begin
      drift_gain[s] = GAIN_RESET[s];
      for (int k = 0; k < 3; k++) begin
        force_acc[s][k] = 0;
        force_zero[s][k] = 0;
      end
      temp_acc[s] = 0;
      acc_count[s] = 0;
      temp_zero[s] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_gain_extremes();
    test_count_saturation();
    test_random_traffic(260, 0, 0);
    test_random_traffic(260, 75, 0);
    test_random_traffic(260, 0, 75);
    test_random_traffic(260, 27, 27);
    test_output_backpressure();

    $display("covered %0d samples on valid sensors and %0d with a bad sensor code",
             n_items, n_ignored);
    $display("checked %0d readings over %0d gain settings, %0d mismatches",
             n_checked, n_settings, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
